[src/cbez_pkg.sv]
// Shared constants for the cubic Bezier point evaluator.
package cbez_pkg;

  localparam int COORD_WIDTH_DEF     = 32;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // One lane per control point of the cubic curve.
  localparam int NUM_POINTS = 4;

endpackage

[src/cbez_weight.sv]
// Two-stage pipeline that forms the four rounded Bernstein weights from t.
module cbez_weight
  import cbez_pkg::*;
#(
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     load_a,
  input  logic                     load_b,
  input  logic [PARAM_FRAC_BITS:0] param_t,
  output logic [PARAM_FRAC_BITS:0] weight [NUM_POINTS]
);

  localparam int TW = PARAM_FRAC_BITS + 1;
  localparam int PW = 2 * TW + 2;
  localparam logic [TW-1:0] ONE  = TW'(1) << PARAM_FRAC_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (PARAM_FRAC_BITS - 1);

  function automatic logic [TW-1:0] rnd_w(input logic [PW-1:0] v);
    logic [PW-1:0] s;
    s = (v + HALF) >> PARAM_FRAC_BITS;
    return s[TW-1:0];
  endfunction

  logic [TW-1:0]   t_clamp;
  logic [TW-1:0]   u_full;
  logic [2*TW-1:0] sq_t;
  logic [2*TW-1:0] sq_u;

  logic [TW-1:0] t_a;
  logic [TW-1:0] u_a;
  logic [TW-1:0] t2_a;
  logic [TW-1:0] u2_a;

  logic [2*TW-1:0] p0;
  logic [2*TW-1:0] p1;
  logic [2*TW-1:0] p2;
  logic [2*TW-1:0] p3;
  logic [PW-1:0]   p1_x3;
  logic [PW-1:0]   p2_x3;

  // Clamp t to one, then square t and 1-t.
  always_comb begin
    t_clamp = (param_t > ONE) ? ONE : param_t;
    u_full  = ONE - t_clamp;
    sq_t    = t_clamp * t_clamp;
    sq_u    = u_full * u_full;
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      t_a  <= t_clamp;
      u_a  <= u_full;
      t2_a <= rnd_w(PW'(sq_t));
      u2_a <= rnd_w(PW'(sq_u));
    end
  end

  // Cubic terms; the factor three is a shift and add.
  always_comb begin
    p0    = u2_a * u_a;
    p1    = u2_a * t_a;
    p2    = t2_a * u_a;
    p3    = t2_a * t_a;
    p1_x3 = PW'(p1) + (PW'(p1) << 1);
    p2_x3 = PW'(p2) + (PW'(p2) << 1);
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      weight[0] <= rnd_w(PW'(p0));
      weight[1] <= rnd_w(p1_x3);
      weight[2] <= rnd_w(p2_x3);
      weight[3] <= rnd_w(PW'(p3));
    end
  end

endmodule

[src/cbez_lane.sv]
// One lane: scales the x and y of one control point by its weight.
module cbez_lane
  import cbez_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        load,
  input  logic signed [COORD_WIDTH-1:0]               coord_x,
  input  logic signed [COORD_WIDTH-1:0]               coord_y,
  input  logic        [PARAM_FRAC_BITS:0]             weight,
  output logic signed [COORD_WIDTH+PARAM_FRAC_BITS+1:0] prod_x,
  output logic signed [COORD_WIDTH+PARAM_FRAC_BITS+1:0] prod_y
);

  logic signed [PARAM_FRAC_BITS+1:0] weight_s;

  // Weight is unsigned; give it a zero sign bit before the signed product.
  assign weight_s = $signed({1'b0, weight});

  always_ff @(posedge clk) begin
    if (load) begin
      prod_x <= coord_x * weight_s;
      prod_y <= coord_y * weight_s;
    end
  end

endmodule

[src/cbez_merge.sv]
// Merge stage: sums the lane products of one axis, rounds and saturates.
module cbez_merge
  import cbez_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          load,
  input  logic signed [COORD_WIDTH+PARAM_FRAC_BITS+1:0] prod [NUM_POINTS],
  output logic signed [COORD_WIDTH-1:0]                 point
);

  localparam int LW = COORD_WIDTH + PARAM_FRAC_BITS + 2;
  localparam int SW = LW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (PARAM_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] CMAX =
    $signed({{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] CMIN = ~CMAX;

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] scaled;
  logic signed [SW-1:0] sat;

  always_comb begin
    sum = HALF;
    for (int i = 0; i < NUM_POINTS; i++) begin
      sum = sum + SW'(prod[i]);
    end
    scaled = sum >>> PARAM_FRAC_BITS;
    if (scaled > CMAX) begin
      sat = CMAX;
    end else if (scaled < CMIN) begin
      sat = CMIN;
    end else begin
      sat = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      point <= sat[COORD_WIDTH-1:0];
    end
  end

endmodule

[src/cubic_bezier_point_eval_core.sv]
// Top level of the cubic Bezier point evaluator: weight pipe, four lanes, merge.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: four control points
//   ctrl0..ctrl3 (signed, 16 fraction bits) and param_t (unsigned Q1.F,
//   values above one clamp to one). Output channel (out_valid/out_ready)
//   returns point_x/point_y, rounded to nearest and saturated.
//   From acceptance to out_valid, two stages form the Bernstein weights,
//   one stage of four lanes multiplies the control points by their
//   weights, and one merge stage sums, rounds and saturates the result.
//   Throughput, with out_ready high, is one item per clock (fully pipelined).
//   Each stage holds its item only while the stage after it is full and
//   stalled, so with out_ready low the pipe keeps filling its empty stages
//   and in_ready drops only once all four stages hold items.
//   Reset (rst, synchronous) empties the pipe; payload registers keep
//   whatever they held. The block keeps no state between items.
module cubic_bezier_point_eval_core
  import cbez_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] ctrl0_x,
  input  logic signed [COORD_WIDTH-1:0] ctrl0_y,
  input  logic signed [COORD_WIDTH-1:0] ctrl1_x,
  input  logic signed [COORD_WIDTH-1:0] ctrl1_y,
  input  logic signed [COORD_WIDTH-1:0] ctrl2_x,
  input  logic signed [COORD_WIDTH-1:0] ctrl2_y,
  input  logic signed [COORD_WIDTH-1:0] ctrl3_x,
  input  logic signed [COORD_WIDTH-1:0] ctrl3_y,
  input  logic        [PARAM_FRAC_BITS:0] param_t,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y
);

  localparam int LW = COORD_WIDTH + PARAM_FRAC_BITS + 2;

  // Stage valids: weight stage a, weight stage b, lane products.
  logic valid_a;
  logic valid_b;
  logic valid_c;

  // Advance when the stage is empty or its content moves on.
  logic adv_out;
  logic adv_c;
  logic adv_b;
  logic adv_a;

  logic load_a;
  logic load_b;
  logic load_c;
  logic load_out;

  // Control points travel beside the weight pipe.
  logic signed [COORD_WIDTH-1:0] cx_in [NUM_POINTS];
  logic signed [COORD_WIDTH-1:0] cy_in [NUM_POINTS];
  logic signed [COORD_WIDTH-1:0] cx_a  [NUM_POINTS];
  logic signed [COORD_WIDTH-1:0] cy_a  [NUM_POINTS];
  logic signed [COORD_WIDTH-1:0] cx_b  [NUM_POINTS];
  logic signed [COORD_WIDTH-1:0] cy_b  [NUM_POINTS];

  logic [PARAM_FRAC_BITS:0] weight [NUM_POINTS];
  logic signed [LW-1:0]     prod_x [NUM_POINTS];
  logic signed [LW-1:0]     prod_y [NUM_POINTS];

  assign cx_in[0] = ctrl0_x;
  assign cy_in[0] = ctrl0_y;
  assign cx_in[1] = ctrl1_x;
  assign cy_in[1] = ctrl1_y;
  assign cx_in[2] = ctrl2_x;
  assign cy_in[2] = ctrl2_y;
  assign cx_in[3] = ctrl3_x;
  assign cy_in[3] = ctrl3_y;

  // Ready ripples back from the output register through each stage.
  always_comb begin
    adv_out  = !out_valid || out_ready;
    adv_c    = !valid_c || adv_out;
    adv_b    = !valid_b || adv_c;
    adv_a    = !valid_a || adv_b;
    in_ready = adv_a;
    load_a   = in_valid && adv_a;
    load_b   = valid_a && adv_b;
    load_c   = valid_b && adv_c;
    load_out = valid_c && adv_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        valid_a <= in_valid;
      end
      if (adv_b) begin
        valid_b <= valid_a;
      end
      if (adv_c) begin
        valid_c <= valid_b;
      end
      if (adv_out) begin
        out_valid <= valid_c;
      end
    end
  end

  // Delay the control points to meet their weights at the lanes.
  always_ff @(posedge clk) begin
    if (load_a) begin
      cx_a <= cx_in;
      cy_a <= cy_in;
    end
    if (load_b) begin
      cx_b <= cx_a;
      cy_b <= cy_a;
    end
  end

  cbez_weight #(
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_weight (
    .clk    (clk),
    .load_a (load_a),
    .load_b (load_b),
    .param_t(param_t),
    .weight (weight)
  );

  for (genvar g = 0; g < NUM_POINTS; g++) begin : g_lane
    cbez_lane #(
      .COORD_WIDTH    (COORD_WIDTH),
      .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .load   (load_c),
      .coord_x(cx_b[g]),
      .coord_y(cy_b[g]),
      .weight (weight[g]),
      .prod_x (prod_x[g]),
      .prod_y (prod_y[g])
    );
  end

  cbez_merge #(
    .COORD_WIDTH    (COORD_WIDTH),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_merge_x (
    .clk  (clk),
    .load (load_out),
    .prod (prod_x),
    .point(point_x)
  );

  cbez_merge #(
    .COORD_WIDTH    (COORD_WIDTH),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_merge_y (
    .clk  (clk),
    .load (load_out),
    .prod (prod_y),
    .point(point_y)
  );

endmodule

[tb/cubic_bezier_point_eval_core_tb.sv]
// Self-checking testbench for the cubic Bezier point evaluator core.
module cubic_bezier_point_eval_core_tb
  import cbez_pkg::*;
;

  localparam int CW     = COORD_WIDTH_DEF;
  localparam int FB     = PARAM_FRAC_BITS_DEF;
  localparam int W_BITS = FB + 4;

  localparam longint ONE_T     = longint'(1) << FB;
  localparam longint HALF_T    = longint'(1) << (FB - 1);
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  localparam logic [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] C_ONES = {CW{1'b1}};
  localparam logic [CW-1:0] C_UNIT = CW'(1) << 16;

  localparam logic [FB:0] T_ZERO = '0;
  localparam logic [FB:0] T_ONE  = (FB+1)'(1) << FB;
  localparam logic [FB:0] T_HALF = (FB+1)'(1) << (FB - 1);
  localparam logic [FB:0] T_TOP  = {(FB+1){1'b1}};

  localparam int N_RANDOM   = 1000;
  localparam int MAX_SHOWN  = 10;
  localparam int CALM_FROM  = 600;
  localparam int CALM_TO    = 1000;
  localparam int HOLD_CYC   = 60;

  typedef struct packed {
    logic [NUM_POINTS-1:0][CW-1:0] cx;
    logic [NUM_POINTS-1:0][CW-1:0] cy;
    logic [FB:0]                   t;
  } curve_item_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } curve_point_t;

  typedef logic [NUM_POINTS-1:0][W_BITS-1:0] weights_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic hold_off = 1'b0;
  curve_item_t cur_item = '0;

  logic                 in_ready;
  logic                 out_valid;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;

  curve_item_t  curve_items_q[$];
  curve_point_t expected_points_q[$];

  int n_accepted = 0;
  int n_errors   = 0;
  int cycle_cnt  = 0;
  logic calm;

  always #2 clk = ~clk;

  cubic_bezier_point_eval_core uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ctrl0_x  (cur_item.cx[0]),
    .ctrl0_y  (cur_item.cy[0]),
    .ctrl1_x  (cur_item.cx[1]),
    .ctrl1_y  (cur_item.cy[1]),
    .ctrl2_x  (cur_item.cx[2]),
    .ctrl2_y  (cur_item.cy[2]),
    .ctrl3_x  (cur_item.cx[3]),
    .ctrl3_y  (cur_item.cy[3]),
    .param_t  (cur_item.t),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .point_x  (point_x),
    .point_y  (point_y)
  );

  // Round to nearest, halves toward +infinity.
  function automatic longint rnd_frac(longint v);
    return (v + HALF_T) >>> FB;
  endfunction

  // Exact weighted sum of one axis, then round and saturate.
  function automatic logic signed [CW-1:0] blend_axis(logic [NUM_POINTS-1:0][CW-1:0] c,
                                                      weights_t w);
    longint acc;
    longint r;
    acc = 0;
    for (int i = 0; i < NUM_POINTS; i++)
      acc += longint'($signed(c[i])) * longint'(w[i]);
    r = rnd_frac(acc);
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < COORD_MIN) r = COORD_MIN;
    return r[CW-1:0];
  endfunction

  // Point on the curve for one item: Bernstein weights, then one blend per axis.
  function automatic curve_point_t eval_curve(curve_item_t it);
    longint tc;
    longint uc;
    longint t2;
    longint u2;
    weights_t w;
    curve_point_t p;
    tc = (longint'(it.t) > ONE_T) ? ONE_T : longint'(it.t);
    uc = ONE_T - tc;
    t2 = rnd_frac(tc * tc);
    u2 = rnd_frac(uc * uc);
    w[0] = W_BITS'(rnd_frac(u2 * uc));
    w[1] = W_BITS'(rnd_frac(3 * u2 * tc));
    w[2] = W_BITS'(rnd_frac(3 * t2 * uc));
    w[3] = W_BITS'(rnd_frac(t2 * tc));
    p.x = blend_axis(it.cx, w);
    p.y = blend_axis(it.cy, w);
    return p;
  endfunction

  function automatic curve_item_t make_item(logic [CW-1:0] p0x, logic [CW-1:0] p0y,
                                            logic [CW-1:0] p1x, logic [CW-1:0] p1y,
                                            logic [CW-1:0] p2x, logic [CW-1:0] p2y,
                                            logic [CW-1:0] p3x, logic [CW-1:0] p3y,
                                            logic [FB:0] t);
    curve_item_t it;
    it.cx = {p3x, p2x, p1x, p0x};
    it.cy = {p3y, p2y, p1y, p0y};
    it.t  = t;
    return it;
  endfunction

  // Moderate and full-range coordinates in equal share, with extreme ones mixed in.
  function automatic logic [CW-1:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4)
      return CW'($urandom_range(0, 2 * 8388608) - 8388608);
    else if (sel < 8)
      return CW'($urandom);
    else if (sel == 8)
      return C_MAX - CW'($urandom_range(0, 3));
    else
      return C_MIN + CW'($urandom_range(0, 3));
  endfunction

  function automatic logic [FB:0] rand_param();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7)
      return (FB+1)'($urandom_range(0, 1 << FB));
    else if (sel == 7)
      return (FB+1)'($urandom_range((1 << FB) + 1, (1 << (FB + 1)) - 1));
    else if (sel == 8)
      return $urandom_range(0, 1) ? (FB+1)'($urandom_range(0, 3))
                                  : T_ONE - (FB+1)'($urandom_range(0, 3));
    else
      return (FB+1)'($urandom);
  endfunction

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Window with no idling on either side.
  assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

  // Driver: hold the item until accepted, then advance or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_points_q.push_back(eval_curve(cur_item));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (curve_items_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          cur_item <= curve_items_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: random stalls, none in the calm window, stalled throughout hold-off, which overrides calm.
  always @(posedge clk) begin
    if (rst || hold_off)
      out_ready <= 1'b0;
    else
      out_ready <= calm || ($urandom_range(0, 99) >= 25);
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_points_q.size() == 0) begin
        n_errors <= n_errors + 1;
        if (n_errors < MAX_SHOWN)
          $display("unexpected result x=%0d y=%0d", point_x, point_y);
      end else begin
        curve_point_t exp_pt;
        exp_pt = expected_points_q.pop_front();
        if (point_x !== exp_pt.x || point_y !== exp_pt.y) begin
          n_errors <= n_errors + 1;
          if (n_errors < MAX_SHOWN)
            $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     exp_pt.x, exp_pt.y, point_x, point_y);
        end
      end
    end
  end

  // Hold the receiver off twice for a long stretch so the pipe fills and stalls the input.
  initial begin
    wait (n_accepted >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_off <= 1'b0;
    wait (n_accepted >= 700);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int drain;
    // Directed items: extremes, clamping of t, rounding ties.
    curve_items_q.push_back(make_item('0, '0, '0, '0, '0, '0, '0, '0, T_ZERO));
    curve_items_q.push_back(make_item(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN,
                                      T_ZERO));
    curve_items_q.push_back(make_item(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX,
                                      T_ONE));
    curve_items_q.push_back(make_item(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                      T_HALF));
    curve_items_q.push_back(make_item(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                      T_HALF));
    curve_items_q.push_back(make_item(C_UNIT, '0, '0, C_UNIT, C_ONES, C_UNIT, C_MAX, C_MIN,
                                      T_TOP));
    curve_items_q.push_back(make_item(C_MIN, C_MAX, C_UNIT, C_ONES, '0, C_UNIT, C_MIN, C_MAX,
                                      T_ONE + (FB+1)'(1)));
    curve_items_q.push_back(make_item(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                      (FB+1)'(1)));
    curve_items_q.push_back(make_item(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                      T_ONE - 1));
    curve_items_q.push_back(make_item(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                      (FB+1)'(21845)));
    curve_items_q.push_back(make_item(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                                      (FB+1)'(43691)));
    curve_items_q.push_back(make_item(C_MIN, C_MAX, '0, '0, '0, '0, C_MAX, C_MIN, T_HALF));
    curve_items_q.push_back(make_item('0, '0, C_UNIT, 2 * C_UNIT, 3 * C_UNIT, -C_UNIT,
                                      4 * C_UNIT, 5 * C_UNIT, T_HALF >> 1));
    curve_items_q.push_back(make_item(C_ONES, C_ONES, C_ONES, C_ONES, C_ONES, C_ONES, C_ONES,
                                      C_ONES, T_HALF + (T_HALF >> 1)));
    curve_items_q.push_back(make_item(CW'(1), CW'(1), CW'(1), CW'(1), CW'(1), CW'(1), CW'(1),
                                      CW'(1), T_HALF));
    curve_items_q.push_back(make_item(C_ONES, CW'(1), C_ONES, CW'(1), C_ONES, CW'(1), C_ONES,
                                      CW'(1), T_HALF));
    curve_items_q.push_back(make_item(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                      T_TOP));
    curve_items_q.push_back(make_item(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                      T_TOP));
    curve_items_q.push_back(make_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                      T_ONE));
    for (int i = 0; i < N_RANDOM; i++)
      curve_items_q.push_back(make_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                        rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                        rand_param()));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for all items to go in, then for the results to drain.
    while (curve_items_q.size() != 0 || in_valid) @(posedge clk);
    drain = 0;
    while (expected_points_q.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (expected_points_q.size() != 0) begin
      $display("%0d expected results never arrived", expected_points_q.size());
      n_errors = n_errors + 1;
    end
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
